@@ sv/sh3_pkg.sv @@
// Shared types and constants for the 3x3 cross sharpen stream.
// No dependencies; imported by every module of the block.
package sh3_pkg;

    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int CHAN_W   = 3;
    localparam int ROW_W    = 12;
    localparam int LEN_W    = WIDTH_W + CHAN_W;
    localparam int PIX_W    = 8;
    localparam int ACC_W    = 12;

    localparam int ADDR_BUS_W = 4;
    localparam int DATA_BUS_W = 32;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH    = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = 13'd480;
    localparam logic [CHAN_W-1:0]   RST_CHANNELS = 3'd3;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH  = 12'd3;
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = 13'd3;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [CHAN_W-1:0]   MIN_CHANNELS = 3'd1;

    // floor(p/3) == (p * RECIP_3) >> RECIP_SHIFT for every p below 2**17
    localparam int RECIP_W = 16;
    localparam logic [RECIP_W-1:0] RECIP_3 = 16'd43691;
    localparam int RECIP_SHIFT = 17;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [WIDTH_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        logic [CHAN_W-1:0]   c;
    } geom_t;

    typedef struct packed {
        logic flush;
        logic produce;
        logic interior;
        logic last;
    } step_t;

endpackage

@@ sv/sh3_cfg.sv @@
// Configuration registers behind the APB-style port, with range clamping.
// Depends on sh3_pkg.
module sh3_cfg #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sh3_pkg::ADDR_BUS_W-1:0]     paddr,
    input  logic [sh3_pkg::DATA_BUS_W-1:0]     pwdata,
    output logic [sh3_pkg::DATA_BUS_W-1:0]     prdata,
    output sh3_pkg::geom_t                     geom
);
    import sh3_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [1:0]          reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            chan_reg   <= RST_CHANNELS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:    width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:   height_reg <= pwdata[HEIGHT_W-1:0];
                REG_CHANNELS: chan_reg   <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:    prdata = DATA_BUS_W'(width_reg);
            REG_HEIGHT:   prdata = DATA_BUS_W'(height_reg);
            REG_CHANNELS: prdata = DATA_BUS_W'(chan_reg);
            default:      prdata = '0;
        endcase
    end

    // saturate each register into its legal range
    always_comb begin
        priority if (width_reg < MIN_WIDTH) begin
            geom.w = MIN_WIDTH;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            geom.w = WIDTH_W'(MAX_WIDTH);
        end else begin
            geom.w = width_reg;
        end

        priority if (height_reg < MIN_HEIGHT) begin
            geom.h = MIN_HEIGHT;
        end else if (height_reg > MAX_HEIGHT) begin
            geom.h = MAX_HEIGHT;
        end else begin
            geom.h = height_reg;
        end

        priority if (chan_reg < MIN_CHANNELS) begin
            geom.c = MIN_CHANNELS;
        end else if (32'(chan_reg) > 32'(MAX_CHANNELS)) begin
            geom.c = CHAN_W'(MAX_CHANNELS);
        end else begin
            geom.c = chan_reg;
        end
    end

endmodule

@@ sv/sh3_seq.sv @@
// Raster position tracking: sample, row and flush counters, border and
// end-of-row decisions, line store addresses. Depends on sh3_pkg.
module sh3_seq #(
    parameter int ADDR_W = 13
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sh3_pkg::geom_t      geom,
    input  logic                accept,
    input  logic                is_flush,
    output sh3_pkg::step_t      step,
    output logic [ADDR_W-1:0]   addr,
    output logic [ADDR_W-1:0]   right_addr
);
    import sh3_pkg::*;

    localparam int PROD_W = ADDR_W + RECIP_W;

    logic [ADDR_W-1:0]   sample_pos_reg, sample_pos_next;
    logic [ADDR_W-1:0]   flush_pos_reg, flush_pos_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [LEN_W-1:0]    len, len_last;
    logic [ADDR_W-1:0]   p, f, col;
    logic [ROW_W-1:0]    row;
    logic [HEIGHT_W-1:0] row_inc;
    logic [PROD_W-1:0]   prod;
    logic                samp_last, flush_last;

    assign len      = LEN_W'(geom.w) * LEN_W'(geom.c);
    assign len_last = len - LEN_W'(1);

    // positions left stale by a geometry change restart at zero
    assign p   = (32'(sample_pos_reg) >= 32'(len)) ? '0 : sample_pos_reg;
    assign f   = (32'(flush_pos_reg) >= 32'(len)) ? '0 : flush_pos_reg;
    assign row = (HEIGHT_W'(row_reg) >= geom.h) ? '0 : row_reg;

    assign samp_last  = (32'(p) == 32'(len_last));
    assign flush_last = (32'(f) == 32'(len_last));

    assign prod = PROD_W'(p) * PROD_W'(RECIP_3);

    always_comb begin
        unique case (geom.c)
            3'd1:    col = p;
            3'd2:    col = p >> 1;
            3'd3:    col = ADDR_W'(prod >> RECIP_SHIFT);
            3'd4:    col = p >> 2;
            default: col = p;
        endcase
    end

    always_comb begin
        step.flush    = is_flush;
        step.produce  = (row != '0);
        step.interior = (row >= ROW_W'(2)) && (col != '0)
                        && (32'(col) != 32'(geom.w - WIDTH_W'(1)));
        step.last     = is_flush ? flush_last : samp_last;
    end

    assign addr       = p;
    assign right_addr = p + ADDR_W'(geom.c);
    assign row_inc    = HEIGHT_W'(row) + HEIGHT_W'(1);

    always_comb begin
        sample_pos_next = sample_pos_reg;
        row_next        = row_reg;
        flush_pos_next  = flush_pos_reg;
        if (accept) begin
            if (is_flush) begin
                flush_pos_next = flush_last ? '0 : f + ADDR_W'(1);
            end else if (samp_last) begin
                sample_pos_next = '0;
                row_next        = (row_inc >= geom.h) ? '0 : ROW_W'(row_inc);
            end else begin
                sample_pos_next = p + ADDR_W'(1);
                row_next        = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_pos_reg <= '0;
            row_reg        <= '0;
            flush_pos_reg  <= '0;
        end else begin
            sample_pos_reg <= sample_pos_next;
            row_reg        <= row_next;
            flush_pos_reg  <= flush_pos_next;
        end
    end

endmodule

@@ sv/sh3_datapath.sv @@
// Line stores, stage register, cross kernel and result register.
// Depends on sh3_pkg; fed by sh3_seq and sh3_cfg.
module sh3_datapath #(
    parameter int DEPTH        = 8192,
    parameter int ADDR_W       = 13,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sh3_pkg::geom_t               geom,
    input  sh3_pkg::step_t               step,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [ADDR_W-1:0]            right_addr,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sh3_pkg::PIX_W-1:0]    s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sh3_pkg::PIX_W-1:0]    m_pixel_out,
    output logic                         m_end_of_row,
    output logic                         m_end_of_frame
);
    import sh3_pkg::*;

    localparam int HIST_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [PIX_W-1:0] recent_mem [DEPTH];
    logic [PIX_W-1:0] older_mem  [DEPTH];
    logic [PIX_W-1:0] hist_reg   [MAX_CHANNELS];

    logic              s1_valid_reg;
    step_t             s1_step_reg;
    logic [PIX_W-1:0]  s1_sample_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  centre_rd_reg, right_rd_reg, upper_rd_reg;

    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              eor_reg, eof_reg;

    logic              accept, out_free, advance, retire_sample;
    logic [HIST_IW-1:0] hist_idx;
    logic [PIX_W-1:0]  left;
    logic [PIX_W+2:0]  centre5;
    logic signed [ACC_W-1:0] acc;
    logic [PIX_W-1:0]  clamped;

    assign out_free      = !m_valid_reg || m_ready;
    assign s_ready       = !s1_valid_reg || out_free;
    assign accept        = s_valid && s_ready;
    assign advance       = s1_valid_reg && out_free;
    assign retire_sample = advance && !s1_step_reg.flush;

    // read-first: the centre read sees last row's value before this beat lands
    always_ff @(posedge aclk) begin
        if (accept) begin
            centre_rd_reg <= recent_mem[addr];
            right_rd_reg  <= recent_mem[right_addr];
            if (!step.flush) begin
                recent_mem[addr] <= s_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (retire_sample) begin
            older_mem[s1_addr_reg] <= centre_rd_reg;
        end
        if (accept) begin
            upper_rd_reg <= older_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_step_reg   <= step;
            s1_sample_reg <= s_sample;
            s1_addr_reg   <= addr;
        end
    end

    // centre values of recent samples; tap c-1 is the left neighbour
    always_ff @(posedge aclk) begin
        if (retire_sample) begin
            for (int i = MAX_CHANNELS - 1; i > 0; i--) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= centre_rd_reg;
        end
    end

    assign hist_idx = HIST_IW'(geom.c - CHAN_W'(1));
    assign left     = hist_reg[hist_idx];
    assign centre5  = {1'b0, centre_rd_reg, 2'b00} + (PIX_W+3)'(centre_rd_reg);

    always_comb begin
        acc = signed'(ACC_W'(centre5))
              - signed'(ACC_W'(left))
              - signed'(ACC_W'(right_rd_reg))
              - signed'(ACC_W'(upper_rd_reg))
              - signed'(ACC_W'(s1_sample_reg));
        priority if (acc < 0) begin
            clamped = '0;
        end else if (acc > signed'(ACC_W'(PIX_MAX))) begin
            clamped = PIX_MAX;
        end else begin
            clamped = acc[PIX_W-1:0];
        end
    end

    always_comb begin
        pix_next = (!s1_step_reg.flush && s1_step_reg.interior) ? clamped : '0;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = s1_valid_reg && (s1_step_reg.flush || s1_step_reg.produce);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pix_reg <= pix_next;
            eor_reg <= s1_step_reg.last;
            eof_reg <= s1_step_reg.flush && s1_step_reg.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_out    = pix_reg;
    assign m_end_of_row   = eor_reg;
    assign m_end_of_frame = eof_reg;

endmodule

@@ sv/sharpen_3x3_cross_stream.sv @@
// 3x3 cross sharpen over an 8-bit interleaved raster stream. Each result is
// 5*centre minus the left, right, upper and lower neighbours of the same
// channel, clamped to 0..255; the first and last rows and columns give zero.
// Output runs one row behind the input, and flush beats emit the bottom zero
// row. One beat is taken every clock while the output is not stalled: the
// two line stores serve their reads (two on the recent line, one on the
// older line) and one write each per beat. A taken sample enters the stage
// register, and its result is loaded into the output register when that is
// free. The line stores come up undefined and need no clearing pass.
// Depends on sh3_pkg, sh3_cfg, sh3_seq and sh3_datapath.
module sharpen_3x3_cross_stream #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [sh3_pkg::PIX_W-1:0]          s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sh3_pkg::PIX_W-1:0]          m_pixel_out,
    output logic                               m_end_of_row,
    output logic                               m_end_of_frame,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sh3_pkg::ADDR_BUS_W-1:0]     paddr,
    input  logic [sh3_pkg::DATA_BUS_W-1:0]     pwdata,
    output logic [sh3_pkg::DATA_BUS_W-1:0]     prdata,
    output logic                               pready
);
    import sh3_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);

    geom_t             geom;
    step_t             step;
    logic [ADDR_W-1:0] addr, right_addr;

    assign pready = 1'b1;

    sh3_cfg #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom)
    );

    sh3_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .accept     (s_valid && s_ready),
        .is_flush   (s_operation),
        .step       (step),
        .addr       (addr),
        .right_addr (right_addr)
    );

    sh3_datapath #(
        .DEPTH        (DEPTH),
        .ADDR_W       (ADDR_W),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .geom           (geom),
        .step           (step),
        .addr           (addr),
        .right_addr     (right_addr),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

@@ sv/sh3_checker.sv @@
// Port-level checks on the sharpen stream's result channel, bound to the top.
// Depends on sh3_pkg.
module sh3_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sh3_pkg::PIX_W-1:0]   m_pixel_out,
    input logic                        m_end_of_row,
    input logic                        m_end_of_frame
);
    import sh3_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out)
        && $stable(m_end_of_row) && $stable(m_end_of_frame))
        else $error("result beat changed while stalled");

    a_eof_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_end_of_row)
        else $error("end of frame without end of row");

    // the end-of-frame beat of the bottom row is border and gives zero
    a_eof_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_pixel_out == '0)
        else $error("non-zero sample on last row");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("channel state not cleared by reset");

endmodule

bind sharpen_3x3_cross_stream sh3_checker u_sh3_checker (.*);
